>>> sv/lr_pkg.sv
// shared types and constants for the line rasterizer
// no dependencies; used by lr_ctrl, lr_datapath and line_rasterizer_top

package lr_pkg;

    // screen defaults
    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 1024;

    // pixels emitted per transaction at most
    localparam int MAX_PIXELS = 64;
    localparam int COUNT_W    = $clog2(MAX_PIXELS);

    // configuration register map
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_ADDR_W-1:0] CFG_BYTES_PER_PIXEL = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_PITCH      = 1'd1;

    localparam logic [3:0]  BPP_RESET   = 4'd4;
    localparam logic [14:0] PITCH_RESET = 15'd4096;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;  // capture a new line from the input transaction
        logic step;  // emit one pixel and advance the walker
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic busy;      // a line walk is in progress
        logic out_free;  // output register can take a pixel this cycle
    } t_status;

endpackage

>>> sv/line_rasterizer_top.sv
// line rasterizer: bresenham walk of one line, up to 64 pixels per input transaction
// an accepted transaction puts the controller into the walk state, where each step
// registers one pixel in the output register, one pixel per cycle while the output
// is not stalled; a stall holds the walk; the input stays blocked until 64 pixels are
// stepped or the line ends; reset is synchronous, active low: walker idle, output empty,
// bytes_per_pixel 4, line_pitch 4096; needs lr_pkg, lr_ctrl, lr_datapath

module line_rasterizer_top #(
    parameter int SCREEN_WIDTH  = lr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = lr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [lr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // line input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [15:0]            i_start_x,
    input  logic signed [15:0]            i_start_y,
    input  logic signed [15:0]            i_end_x,
    input  logic signed [15:0]            i_end_y,
    // pixel output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [15:0]            o_pixel_x,
    output logic signed [15:0]            o_pixel_y,
    output logic                          o_visible,
    output logic [23:0]                   o_byte_offset,
    output logic                          o_last
);

    lr_pkg::t_cmd    cmd;
    lr_pkg::t_status status;

    // controller: accepts a transaction in idle, then walks up to 64 pixels;
    // while a line is still unfinished the next transaction just continues it
    lr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // datapath: bresenham walker, screen clip, byte offset, output register
    // (the output register lets a new transaction in while the last pixel waits)
    lr_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_visible     (o_visible),
        .o_byte_offset (o_byte_offset),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    // walker never steps in the cycle a transaction is taken
    a_no_step_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && i_in_valid && cmd.step))
        else $error("walker stepped during input transaction");

    // a step needs a live line and room in the output register
    a_step_guarded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> (status.busy && status.out_free))
        else $error("step without busy line or free output");

    // a step always shows up as a valid pixel next cycle
    a_step_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |=> o_out_valid)
        else $error("stepped pixel not presented");

    // a new line is loaded only by an accepted transaction
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (o_in_ready && i_in_valid && !status.busy))
        else $error("line loaded outside input transaction");
`endif

endmodule

>>> sv/lr_ctrl.sv
// controller for the line rasterizer: idle/walk state machine and pixel counter
// depends on lr_pkg

module lr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  lr_pkg::t_status i_status,
    output logic            o_in_ready,
    output lr_pkg::t_cmd    o_cmd
);

    lr_pkg::t_state r_state, n_state;
    logic [lr_pkg::COUNT_W-1:0] r_count, n_count;
    logic accept;

    assign o_in_ready = (r_state == lr_pkg::ST_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        o_cmd.load = accept && !i_status.busy;
        o_cmd.step = (r_state == lr_pkg::ST_WALK) && i_status.busy && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            lr_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = lr_pkg::ST_WALK;
                    n_count = '0;
                end
            end
            lr_pkg::ST_WALK: begin
                if (!i_status.busy) begin
                    n_state = lr_pkg::ST_IDLE;
                end else if (o_cmd.step) begin
                    n_count = r_count + 1'b1;
                    if (r_count == lr_pkg::COUNT_W'(lr_pkg::MAX_PIXELS - 1)) begin
                        n_state = lr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = lr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lr_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

>>> sv/lr_datapath.sv
// datapath for the line rasterizer: walker registers, error update, clip,
// offset multiply and output register; depends on lr_pkg

module lr_datapath #(
    parameter int SCREEN_WIDTH  = lr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = lr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic signed [15:0]            i_start_x,
    input  logic signed [15:0]            i_start_y,
    input  logic signed [15:0]            i_end_x,
    input  logic signed [15:0]            i_end_y,
    input  lr_pkg::t_cmd                  i_cmd,
    output lr_pkg::t_status               o_status,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [15:0]            o_pixel_x,
    output logic signed [15:0]            o_pixel_y,
    output logic                          o_visible,
    output logic [23:0]                   o_byte_offset,
    output logic                          o_last
);

    // configuration
    logic [3:0]  r_bpp;
    logic [14:0] r_pitch;

    // walker state
    logic signed [15:0] r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic signed [18:0] r_err;
    logic [16:0]        r_span_x, r_span_y;
    logic               r_dir_x_neg, r_dir_y_neg;
    logic               r_busy;

    // output register
    logic               r_out_valid;
    logic signed [15:0] r_px, r_py;
    logic               r_vis, r_last;
    logic [23:0]        r_off;

    // load path
    logic signed [16:0] dx, dy;
    logic [16:0]        ld_span_x, ld_span_y;

    // step path
    logic signed [19:0] e2, span_x_ext, span_y_ext;
    logic               move_x, move_y;
    logic signed [18:0] n_err;
    logic signed [15:0] n_cur_x, n_cur_y;
    logic               n_busy;
    logic               vis;
    logic [18:0]        prod_x;
    logic [29:0]        prod_y;
    logic [23:0]        off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp   <= lr_pkg::BPP_RESET;
            r_pitch <= lr_pkg::PITCH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                lr_pkg::CFG_BYTES_PER_PIXEL: r_bpp   <= i_cfg_data[3:0];
                lr_pkg::CFG_LINE_PITCH:      r_pitch <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        dx = {i_end_x[15], i_end_x} - {i_start_x[15], i_start_x};
        dy = {i_end_y[15], i_end_y} - {i_start_y[15], i_start_y};
        ld_span_x = dx[16] ? 17'(-dx) : 17'(dx);
        ld_span_y = dy[16] ? 17'(-dy) : 17'(dy);
    end

    always_comb begin
        e2         = {r_err, 1'b0};
        span_x_ext = $signed({3'b000, r_span_x});
        span_y_ext = $signed({3'b000, r_span_y});
        move_x     = e2 > -span_y_ext;
        move_y     = e2 < span_x_ext;
        n_err = r_err - (move_x ? $signed({2'b00, r_span_y}) : 19'sd0)
                      + (move_y ? $signed({2'b00, r_span_x}) : 19'sd0);
        n_cur_x = move_x ? (r_dir_x_neg ? r_cur_x - 16'sd1 : r_cur_x + 16'sd1) : r_cur_x;
        n_cur_y = move_y ? (r_dir_y_neg ? r_cur_y - 16'sd1 : r_cur_y + 16'sd1) : r_cur_y;
        n_busy  = !((n_cur_x == r_tgt_x) && (n_cur_y == r_tgt_y));
        vis = !r_cur_x[15] && (r_cur_x[14:0] < 15'(SCREEN_WIDTH))
           && !r_cur_y[15] && (r_cur_y[14:0] < 15'(SCREEN_HEIGHT));
        prod_x = r_cur_x[14:0] * r_bpp;
        prod_y = r_cur_y[14:0] * r_pitch;
        off    = vis ? 24'(31'(prod_x) + 31'(prod_y)) : 24'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.load) begin
            r_busy <= (i_start_x != i_end_x) || (i_start_y != i_end_y);
        end else if (i_cmd.step) begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_x     <= i_start_x;
            r_cur_y     <= i_start_y;
            r_tgt_x     <= i_end_x;
            r_tgt_y     <= i_end_y;
            r_span_x    <= ld_span_x;
            r_span_y    <= ld_span_y;
            r_dir_x_neg <= !(i_end_x > i_start_x);
            r_dir_y_neg <= !(i_end_y > i_start_y);
            r_err       <= $signed({2'b00, ld_span_x}) - $signed({2'b00, ld_span_y});
        end else if (i_cmd.step) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_px   <= r_cur_x;
            r_py   <= r_cur_y;
            r_vis  <= vis;
            r_off  <= off;
            r_last <= !n_busy;
        end
    end

    assign o_status.busy     = r_busy;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_visible     = r_vis;
    assign o_byte_offset = r_off;
    assign o_last        = r_last;

endmodule
